@@ hdl/srti_pkg.sv @@
package srti_pkg;

  // Offset subtracted from the scaled rate before the table lookup
  localparam int unsigned MinRate = 32;

  localparam int unsigned RateW = 16;
  localparam int unsigned IvW   = 16;
  localparam int unsigned MultW = 3;
  // Scaled rate never exceeds 16383
  localparam int unsigned SclW  = 14;

  localparam logic [RateW-1:0] MaxRateReset = 16'd40000;
  localparam logic [RateW-1:0] QuadLimit    = 16'd20000;
  localparam logic [RateW-1:0] DoubleLimit  = 16'd10000;
  localparam logic [SclW-1:0]  FastSplit    = 14'd2048;
  localparam logic [IvW-1:0]   MinInterval  = 16'd100;

  localparam logic [MultW-1:0] MultOne  = 3'd1;
  localparam logic [MultW-1:0] MultTwo  = 3'd2;
  localparam logic [MultW-1:0] MultFour = 3'd4;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] slope;
  } rom_entry_t;

  localparam rom_entry_t FAST_ROM [256] = '{
   '{62500, 54055}, '{8445, 3917}, '{4528, 1434}, '{3094, 745}, '{2349, 456}, '{1893, 307},
   '{1586, 222}, '{1364, 167},
   '{1197, 131}, '{1066, 105}, '{961, 86}, '{875, 72}, '{803, 61}, '{742, 53}, '{689, 45},
   '{644, 40},
   '{604, 35}, '{569, 32}, '{537, 28}, '{509, 25}, '{484, 23}, '{461, 21}, '{440, 19},
   '{421, 17},
   '{404, 16}, '{388, 15}, '{373, 14}, '{359, 13}, '{346, 12}, '{334, 11}, '{323, 10},
   '{313, 10},
   '{303, 9}, '{294, 9}, '{285, 8}, '{277, 7}, '{270, 8}, '{262, 7}, '{255, 6}, '{249, 6},
   '{243, 6}, '{237, 6}, '{231, 5}, '{226, 5}, '{221, 5}, '{216, 5}, '{211, 4}, '{207, 5},
   '{202, 4}, '{198, 4}, '{194, 4}, '{190, 3}, '{187, 4}, '{183, 3}, '{180, 3}, '{177, 4},
   '{173, 3}, '{170, 3}, '{167, 2}, '{165, 3}, '{162, 3}, '{159, 2}, '{157, 3}, '{154, 2},
   '{152, 3}, '{149, 2}, '{147, 2}, '{145, 2}, '{143, 2}, '{141, 2}, '{139, 2}, '{137, 2},
   '{135, 2}, '{133, 2}, '{131, 2}, '{129, 1}, '{128, 2}, '{126, 2}, '{124, 1}, '{123, 2},
   '{121, 1}, '{120, 2}, '{118, 1}, '{117, 1}, '{116, 2}, '{114, 1}, '{113, 1}, '{112, 2},
   '{110, 1}, '{109, 1}, '{108, 1}, '{107, 2}, '{105, 1}, '{104, 1}, '{103, 1}, '{102, 1},
   '{101, 1}, '{100, 1}, '{99, 1}, '{98, 1}, '{97, 1}, '{96, 1}, '{95, 1}, '{94, 1},
   '{93, 1}, '{92, 1}, '{91, 0}, '{91, 1}, '{90, 1}, '{89, 1}, '{88, 1}, '{87, 0},
   '{87, 1}, '{86, 1}, '{85, 1}, '{84, 0}, '{84, 1}, '{83, 1}, '{82, 1}, '{81, 0},
   '{81, 1}, '{80, 1}, '{79, 0}, '{79, 1}, '{78, 0}, '{78, 1}, '{77, 1}, '{76, 0},
   '{76, 1}, '{75, 0}, '{75, 1}, '{74, 1}, '{73, 0}, '{73, 1}, '{72, 0}, '{72, 1},
   '{71, 0}, '{71, 1}, '{70, 0}, '{70, 1}, '{69, 0}, '{69, 1}, '{68, 0}, '{68, 1},
   '{67, 0}, '{67, 1}, '{66, 0}, '{66, 1}, '{65, 0}, '{65, 0}, '{65, 1}, '{64, 0},
   '{64, 1}, '{63, 0}, '{63, 1}, '{62, 0}, '{62, 0}, '{62, 1}, '{61, 0}, '{61, 1},
   '{60, 0}, '{60, 0}, '{60, 1}, '{59, 0}, '{59, 0}, '{59, 1}, '{58, 0}, '{58, 0},
   '{58, 1}, '{57, 0}, '{57, 0}, '{57, 1}, '{56, 0}, '{56, 0}, '{56, 1}, '{55, 0},
   '{55, 0}, '{55, 1}, '{54, 0}, '{54, 0}, '{54, 1}, '{53, 0}, '{53, 0}, '{53, 0},
   '{53, 1}, '{52, 0}, '{52, 0}, '{52, 1}, '{51, 0}, '{51, 0}, '{51, 0}, '{51, 1},
   '{50, 0}, '{50, 0}, '{50, 0}, '{50, 1}, '{49, 0}, '{49, 0}, '{49, 0}, '{49, 1},
   '{48, 0}, '{48, 0}, '{48, 0}, '{48, 1}, '{47, 0}, '{47, 0}, '{47, 0}, '{47, 1},
   '{46, 0}, '{46, 0}, '{46, 0}, '{46, 0}, '{46, 1}, '{45, 0}, '{45, 0}, '{45, 0},
   '{45, 1}, '{44, 0}, '{44, 0}, '{44, 0}, '{44, 0}, '{44, 1}, '{43, 0}, '{43, 0},
   '{43, 0}, '{43, 0}, '{43, 1}, '{42, 0}, '{42, 0}, '{42, 0}, '{42, 0}, '{42, 0},
   '{42, 1}, '{41, 0}, '{41, 0}, '{41, 0}, '{41, 0}, '{41, 0}, '{41, 1}, '{40, 0},
   '{40, 0}, '{40, 0}, '{40, 0}, '{40, 1}, '{39, 0}, '{39, 0}, '{39, 0}, '{39, 0},
   '{39, 0}, '{39, 0}, '{39, 1}, '{38, 0}, '{38, 0}, '{38, 0}, '{38, 0}, '{38, 0}
  };

  localparam rom_entry_t SLOW_ROM [256] = '{
   '{62500, 10417}, '{52083, 7441}, '{44642, 5580}, '{39062, 4340}, '{34722, 3472},
   '{31250, 2841}, '{28409, 2368}, '{26041, 2003},
   '{24038, 1717}, '{22321, 1488}, '{20833, 1302}, '{19531, 1149}, '{18382, 1021},
   '{17361, 914}, '{16447, 822}, '{15625, 745},
   '{14880, 676}, '{14204, 618}, '{13586, 566}, '{13020, 520}, '{12500, 481}, '{12019, 445},
   '{11574, 414}, '{11160, 385},
   '{10775, 359}, '{10416, 336}, '{10080, 315}, '{9765, 296}, '{9469, 278}, '{9191, 263},
   '{8928, 248}, '{8680, 235},
   '{8445, 222}, '{8223, 211}, '{8012, 200}, '{7812, 191}, '{7621, 181}, '{7440, 173},
   '{7267, 165}, '{7102, 158},
   '{6944, 151}, '{6793, 145}, '{6648, 138}, '{6510, 133}, '{6377, 127}, '{6250, 123},
   '{6127, 118}, '{6009, 113},
   '{5896, 109}, '{5787, 106}, '{5681, 101}, '{5580, 98}, '{5482, 95}, '{5387, 91},
   '{5296, 88}, '{5208, 86},
   '{5122, 82}, '{5040, 80}, '{4960, 78}, '{4882, 75}, '{4807, 73}, '{4734, 70},
   '{4664, 69}, '{4595, 67},
   '{4528, 64}, '{4464, 63}, '{4401, 61}, '{4340, 60}, '{4280, 58}, '{4222, 56},
   '{4166, 55}, '{4111, 53},
   '{4058, 52}, '{4006, 51}, '{3955, 49}, '{3906, 48}, '{3858, 48}, '{3810, 45},
   '{3765, 45}, '{3720, 44},
   '{3676, 43}, '{3633, 42}, '{3591, 40}, '{3551, 40}, '{3511, 39}, '{3472, 38},
   '{3434, 38}, '{3396, 36},
   '{3360, 36}, '{3324, 35}, '{3289, 34}, '{3255, 34}, '{3221, 33}, '{3188, 32},
   '{3156, 31}, '{3125, 31},
   '{3094, 31}, '{3063, 30}, '{3033, 29}, '{3004, 28}, '{2976, 28}, '{2948, 28},
   '{2920, 27}, '{2893, 27},
   '{2866, 26}, '{2840, 25}, '{2815, 25}, '{2790, 25}, '{2765, 24}, '{2741, 24},
   '{2717, 24}, '{2693, 23},
   '{2670, 22}, '{2648, 22}, '{2626, 22}, '{2604, 22}, '{2582, 21}, '{2561, 21},
   '{2540, 20}, '{2520, 20},
   '{2500, 20}, '{2480, 20}, '{2460, 19}, '{2441, 19}, '{2422, 19}, '{2403, 18},
   '{2385, 18}, '{2367, 18},
   '{2349, 17}, '{2332, 18}, '{2314, 17}, '{2297, 16}, '{2281, 17}, '{2264, 16},
   '{2248, 16}, '{2232, 16},
   '{2216, 16}, '{2200, 15}, '{2185, 15}, '{2170, 15}, '{2155, 15}, '{2140, 15},
   '{2125, 14}, '{2111, 14},
   '{2097, 14}, '{2083, 14}, '{2069, 14}, '{2055, 13}, '{2042, 13}, '{2029, 13},
   '{2016, 13}, '{2003, 13},
   '{1990, 13}, '{1977, 12}, '{1965, 12}, '{1953, 13}, '{1940, 11}, '{1929, 12},
   '{1917, 12}, '{1905, 12},
   '{1893, 11}, '{1882, 11}, '{1871, 11}, '{1860, 11}, '{1849, 11}, '{1838, 11},
   '{1827, 11}, '{1816, 10},
   '{1806, 11}, '{1795, 10}, '{1785, 10}, '{1775, 10}, '{1765, 10}, '{1755, 10},
   '{1745, 9}, '{1736, 10},
   '{1726, 9}, '{1717, 10}, '{1707, 9}, '{1698, 9}, '{1689, 9}, '{1680, 9}, '{1671, 9},
   '{1662, 9},
   '{1653, 9}, '{1644, 8}, '{1636, 9}, '{1627, 8}, '{1619, 9}, '{1610, 8}, '{1602, 8},
   '{1594, 8},
   '{1586, 8}, '{1578, 8}, '{1570, 8}, '{1562, 8}, '{1554, 7}, '{1547, 8}, '{1539, 8},
   '{1531, 7},
   '{1524, 8}, '{1516, 7}, '{1509, 7}, '{1502, 7}, '{1495, 7}, '{1488, 7}, '{1481, 7},
   '{1474, 7},
   '{1467, 7}, '{1460, 7}, '{1453, 7}, '{1446, 6}, '{1440, 7}, '{1433, 7}, '{1426, 6},
   '{1420, 6},
   '{1414, 7}, '{1407, 6}, '{1401, 6}, '{1395, 7}, '{1388, 6}, '{1382, 6}, '{1376, 6},
   '{1370, 6},
   '{1364, 6}, '{1358, 6}, '{1352, 6}, '{1346, 5}, '{1341, 6}, '{1335, 6}, '{1329, 5},
   '{1324, 6},
   '{1318, 5}, '{1313, 6}, '{1307, 5}, '{1302, 6}, '{1296, 5}, '{1291, 5}, '{1286, 6},
   '{1280, 5},
   '{1275, 5}, '{1270, 5}, '{1265, 5}, '{1260, 5}, '{1255, 5}, '{1250, 5}, '{1245, 5},
   '{1240, 5},
   '{1235, 5}, '{1230, 5}, '{1225, 5}, '{1220, 5}, '{1215, 4}, '{1211, 5}, '{1206, 5},
   '{1201, 5}
  };

endpackage

@@ hdl/step_rate_to_timer_interval.sv @@
// Stages: the input transaction loads the input register, then the result register;
//   a result held by out_ready_i low can stall both stages.
// Throughput: one transaction per cycle unless the output stalls; the table lookup,
//   one 16x8 multiply and the subtract and clamp sit between the two registers.
// Reset: both stages empty, max_step_rate returns to 40000.
module step_rate_to_timer_interval
  import srti_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [RateW-1:0] max_step_rate_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RateW-1:0] step_rate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IvW-1:0]   timer_interval_o,
  output logic [MultW-1:0] steps_per_tick_o
);

  logic [RateW-1:0] max_rate_q;
  logic             in_vld_q;
  logic [RateW-1:0] rate_q;
  logic             out_vld_q;
  logic [IvW-1:0]   iv_q, iv_d;
  logic [MultW-1:0] mult_q, mult_d;
  logic             s2_ready, s1_ready;

  logic [RateW-1:0] clamped;
  logic [SclW-1:0]  scaled, off_rate;
  logic             use_fast;
  rom_entry_t       entry;
  logic [7:0]       frac;
  logic [23:0]      prod;
  logic [IvW-1:0]   step_down, ticks;

  assign cfg_ready_o = 1'b1;
  assign s2_ready    = !out_vld_q || out_ready_i;
  assign s1_ready    = !in_vld_q || s2_ready;
  assign in_ready_o  = s1_ready;

  // Hold the rate limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= MaxRateReset;
    end else if (cfg_valid_i) begin
      max_rate_q <= max_step_rate_i;
    end
  end

  // Clamp, prescale and pick the table entry
  always_comb begin
    clamped = (rate_q > max_rate_q) ? max_rate_q : rate_q;
    if (clamped > QuadLimit) begin
      scaled = clamped[SclW+1:2];
      mult_d = MultFour;
    end else if (clamped > DoubleLimit) begin
      scaled = clamped[SclW:1];
      mult_d = MultTwo;
    end else begin
      scaled = clamped[SclW-1:0];
      mult_d = MultOne;
    end
    off_rate = (scaled > SclW'(MinRate)) ? scaled - SclW'(MinRate) : '0;
    use_fast = off_rate >= FastSplit;
    if (use_fast) begin
      entry = FAST_ROM[{2'b00, off_rate[SclW-1:8]}];
      frac  = off_rate[7:0];
    end else begin
      entry = SLOW_ROM[off_rate[10:3]];
      frac  = {5'd0, off_rate[2:0]};
    end
  end

  // Interpolate and clamp to the minimum interval
  always_comb begin
    prod      = 24'(entry.slope) * 24'(frac);
    step_down = use_fast ? prod[23:8] : prod[18:3];
    ticks     = (entry.base > step_down) ? entry.base - step_down : '0;
    iv_d      = (ticks < MinInterval) ? MinInterval : ticks;
  end

  // Advance the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      rate_q <= step_rate_i;
    end
    if (s2_ready && in_vld_q) begin
      iv_q   <= iv_d;
      mult_q <= mult_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign timer_interval_o = iv_q;
  assign steps_per_tick_o = mult_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import srti_pkg::*;

  typedef struct {
    logic [IvW-1:0]   interval;
    logic [MultW-1:0] mult;
  } timing_t;

  typedef struct {
    logic [RateW-1:0] rate;
    bit               typed;
    logic [IvW-1:0]   interval;
    logic [MultW-1:0] mult;
  } rate_row_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [RateW-1:0] max_step_rate_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [RateW-1:0] step_rate_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [IvW-1:0]   timer_interval_o;
  logic [MultW-1:0] steps_per_tick_o;

  logic [RateW-1:0] rate_cap;
  timing_t          pending_q[$];
  int unsigned      mismatches;
  int unsigned      rates_sent;
  int unsigned      timings_seen;
  int unsigned      cycles;
  bit               tx_steady;
  // receiver mode: 0 random, 1 always ready, 2 long hold
  int unsigned      rx_mode;

  step_rate_to_timer_interval dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .max_step_rate_i (max_step_rate_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .step_rate_i     (step_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .timer_interval_o(timer_interval_o),
    .steps_per_tick_o(steps_per_tick_o)
  );

  // Generate clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predict interval and step multiplier for one rate under the current cap
  function automatic timing_t rate_to_timing(logic [RateW-1:0] rate);
    timing_t     res;
    logic [31:0] r;
    logic [31:0] drop;
    rom_entry_t  e;
    r = 32'((rate > rate_cap) ? rate_cap : rate);
    if (r > QuadLimit) begin
      r = r >> 2;
      res.mult = MultFour;
    end else if (r > DoubleLimit) begin
      r = r >> 1;
      res.mult = MultTwo;
    end else begin
      res.mult = MultOne;
    end
    r = (r > MinRate) ? r - MinRate : 0;
    if (r >= FastSplit) begin
      e = FAST_ROM[r[15:8]];
      drop = (32'(e.slope) * (r & 32'hff)) >> 8;
    end else begin
      e = SLOW_ROM[r[10:3]];
      drop = (32'(e.slope) * (r & 32'h7)) >> 3;
    end
    drop = (32'(e.base) > drop) ? 32'(e.base) - drop : 0;
    if (drop < 32'(MinInterval)) drop = 32'(MinInterval);
    res.interval = drop[15:0];
    return res;
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d timings pending", cycles, pending_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // Drive result-side ready
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_mode == 2) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_mode = 0;
      end
      out_ready_i = (rx_mode == 1) ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    timing_t exp_t;
    if (rst_ni && out_valid_o && out_ready_i) begin
      timings_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: interval %0d mult %0d",
                   timer_interval_o, steps_per_tick_o);
      end else begin
        exp_t = pending_q.pop_front();
        if (timer_interval_o !== exp_t.interval || steps_per_tick_o !== exp_t.mult) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: interval exp %0d got %0d, mult exp %0d got %0d",
                     exp_t.interval, timer_interval_o, exp_t.mult, steps_per_tick_o);
        end
      end
    end
  end

  // Write the rate cap once the block is drained
  task automatic write_cap(logic [RateW-1:0] cap);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    max_step_rate_i = cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    rate_cap = cap;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one rate; expectation may be typed in or predicted
  task automatic send_rate(logic [RateW-1:0] rate, bit typed, timing_t typed_t);
    if (!tx_steady && $urandom_range(99) < 32) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    step_rate_i = rate;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(typed ? typed_t : rate_to_timing(rate));
    rates_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [RateW-1:0] pick_rate();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return RateW'($urandom_range(65535));
    if (sel < 70) return RateW'($urandom_range(2200));
    if (sel < 85) return RateW'($urandom_range(10010, 9990));
    return RateW'($urandom_range(20010, 19990));
  endfunction

  initial begin
    rate_row_t        rows[$];
    timing_t          t;
    logic [RateW-1:0] caps[6];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    max_step_rate_i = '0;
    in_valid_i = 1'b0;
    step_rate_i = '0;
    rate_cap = MaxRateReset;
    mismatches = 0;
    rates_sent = 0;
    timings_seen = 0;
    cycles = 0;
    tx_steady = 1'b0;
    rx_mode = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows under the reset cap
    rows = '{
      '{16'd0,     1, 16'd62500, MultOne},
      '{16'd32,    1, 16'd62500, MultOne},
      '{16'd33,    0, 16'd0, MultOne},
      '{16'd65535, 1, 16'd250,   MultFour},
      '{16'd40000, 1, 16'd250,   MultFour},
      '{16'd40001, 0, 16'd0, MultOne},
      '{16'd10000, 0, 16'd0, MultOne},
      '{16'd10001, 0, 16'd0, MultOne},
      '{16'd20000, 0, 16'd0, MultOne},
      '{16'd20001, 0, 16'd0, MultOne},
      '{16'd2079,  0, 16'd0, MultOne},
      '{16'd2080,  0, 16'd0, MultOne},
      '{16'd2081,  0, 16'd0, MultOne},
      '{16'd4255,  0, 16'd0, MultOne},
      '{16'd8224,  0, 16'd0, MultOne},
      '{16'd21845, 0, 16'd0, MultOne},
      '{16'd43690, 0, 16'd0, MultOne},
      '{16'd1,     0, 16'd0, MultOne},
      '{16'd39,    0, 16'd0, MultOne}
    };
    foreach (rows[i]) begin
      t.interval = rows[i].interval;
      t.mult = rows[i].mult;
      send_rate(rows[i].rate, rows[i].typed, t);
    end
    in_valid_i = 1'b0;

    // Zero cap: every rate lands on the first slow entry
    write_cap(16'd0);
    t.interval = 16'd62500;
    t.mult = MultOne;
    send_rate(16'd65535, 1, t);
    send_rate(16'd12345, 1, t);
    in_valid_i = 1'b0;

    // Random phases over several caps, extremes included
    caps = '{16'd65535, 16'd0, 16'd10000, 16'd20001, MaxRateReset,
             RateW'($urandom_range(65535))};
    foreach (caps[p]) begin
      write_cap(caps[p]);
      tx_steady = (p == 2);
      rx_mode = (p == 2) ? 1 : 0;
      for (int n = 0; n < 305; n++) begin
        if (n == 100 && p == 0) rx_mode = 2;
        send_rate(pick_rate(), 0, t);
      end
      in_valid_i = 1'b0;
      rx_mode = 0;
    end
    tx_steady = 1'b0;

    // Drain and settle
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("sent %0d rates over %0d caps, checked %0d timings, %0d mismatches",
             rates_sent, 8, timings_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
